// ----- design/touch_controller_sample_scaler_assert.svh -----
// Assertion macros for the touch controller sample scaler.
`ifndef TOUCH_CONTROLLER_SAMPLE_SCALER_ASSERT_SVH
`define TOUCH_CONTROLLER_SAMPLE_SCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCSS_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("touch_controller_sample_scaler: same-cycle check failed");
`define TCSS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("touch_controller_sample_scaler: next-cycle check failed");
`else
`define TCSS_ASSERT_IMP(label, cond, prop)
`define TCSS_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ----- design/tcss_pkg.sv -----
// Shared types and constants of the touch controller sample scaler.
package tcss_pkg;

  localparam int RAW_W      = 12;
  localparam int WORD_W     = 16;
  localparam int QUOT_W     = 9;
  localparam int DIVIDEND_W = 21;
  localparam int STEP_W     = 4;
  localparam int SX_W       = 9;
  localparam int SY_W       = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - WORD_W - 2 - SX_W - SY_W + 1;

  localparam logic [WORD_W-1:0] TX_Y_CMD = 16'h9000;
  localparam logic [WORD_W-1:0] TX_FLUSH = 16'h0000;
  localparam logic [WORD_W-1:0] TX_START = 16'hD000;

  localparam logic [SX_W-1:0] X_SPAN = 9'd320;
  localparam logic [SY_W-1:0] Y_SPAN = 8'd240;

  localparam logic [RAW_W-1:0] X_HIGH_RESET = 12'd3900;
  localparam logic [RAW_W-1:0] X_LOW_RESET  = 12'd200;
  localparam logic [RAW_W-1:0] Y_LOW_RESET  = 12'd200;
  localparam logic [RAW_W-1:0] Y_HIGH_RESET = 12'd3900;

  typedef enum logic [1:0] {
    REG_X_RAW_HIGH = 2'd0,
    REG_X_RAW_LOW  = 2'd1,
    REG_Y_RAW_LOW  = 2'd2,
    REG_Y_RAW_HIGH = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WORD_FIRST  = 2'd0,
    WORD_SECOND = 2'd1,
    WORD_THIRD  = 2'd2
  } word_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_DIV  = 2'd2
  } state_t;

endpackage

// ----- design/tcss_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module tcss_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tcss_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [tcss_pkg::RAW_W-1:0]       divisor,
  output logic [tcss_pkg::QUOT_W-1:0]      quotient,
  output logic                             done
);
  import tcss_pkg::*;

  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] rem_next;
  logic [DIVIDEND_W-1:0] dsh;
  logic [STEP_W-1:0]     count;
  logic                  fits;

  assign fits     = (rem >= dsh);
  assign rem_next = fits ? (rem - dsh) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= STEP_W'(QUOT_W);
      end else if (count != '0) begin
        count <= count - STEP_W'(1);
        done  <= (count == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DIVIDEND_W'({divisor, {(QUOT_W-1){1'b0}}});
      quotient <= '0;
    end else if (count != '0) begin
      rem      <= rem_next;
      dsh      <= dsh >> 1;
      quotient <= {quotient[QUOT_W-2:0], fits};
    end
  end

endmodule

// ----- design/touch_controller_sample_scaler.sv -----
// Top level of the touch controller sample scaler.
//
// Every received converter word gives one result: the next word to send, and on
// the third word of a conversion the calibrated screen position. The first and
// second words of a conversion are answered in the cycle after their acceptance.
// The raw fields are joined and clamped as the third word is accepted. The prep
// state then forms the scaled numerators and starts the dividers. The x and y
// restoring dividers run side by side, one quotient bit per cycle, and their
// quotients are then moved into the output register. The input is not ready
// while a position is being computed or while an unread result blocks the
// output register.
`include "touch_controller_sample_scaler_assert.svh"

module touch_controller_sample_scaler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] rx_word
  input  logic [tcss_pkg::WORD_W-1:0]       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] next_tx_word, [16] release_select, [25:17] screen_x,
  // [33:26] screen_y, [39:34] zero
  output logic [tcss_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] position_valid
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [tcss_pkg::RAW_W-1:0]        cfg_data
);
  import tcss_pkg::*;

  state_t state;
  state_t state_next;

  logic [RAW_W-1:0] x_high;
  logic [RAW_W-1:0] x_low;
  logic [RAW_W-1:0] y_low;
  logic [RAW_W-1:0] y_high;

  logic [1:0]       word_index;
  logic [6:0]       first_low;
  logic [RAW_W-1:0] y_raw;
  logic [6:0]       x_top;

  logic [RAW_W-1:0] x_join;
  logic [RAW_W-1:0] x_zero;
  logic [RAW_W-1:0] x_clamp;
  logic [RAW_W-1:0] y_clamp;
  logic [RAW_W-1:0] xc;
  logic [RAW_W-1:0] yc;

  logic [RAW_W-1:0]      x_num;
  logic [RAW_W-1:0]      x_den;
  logic [RAW_W-1:0]      y_num;
  logic [RAW_W-1:0]      y_den;
  logic [DIVIDEND_W-1:0] x_dividend;
  logic [DIVIDEND_W-1:0] y_dividend;
  logic [QUOT_W-1:0]     x_quot;
  logic [QUOT_W-1:0]     y_quot;
  logic                  x_done;
  logic                  y_done;
  logic                  div_start;

  logic              s_accept;
  logic              m_accept;
  logic [WORD_W-1:0] tx_word;
  logic              release_sel;
  logic              pos_valid;
  logic [SX_W-1:0]   screen_x;
  logic [SY_W-1:0]   screen_y;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  assign m_tdata = {{OUT_PAD_W{1'b0}}, screen_y, screen_x, release_sel, tx_word};
  assign m_tuser = pos_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_high <= X_HIGH_RESET;
      x_low  <= X_LOW_RESET;
      y_low  <= Y_LOW_RESET;
      y_high <= Y_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_RAW_HIGH: x_high <= cfg_data;
        REG_X_RAW_LOW:  x_low  <= cfg_data;
        REG_Y_RAW_LOW:  y_low  <= cfg_data;
        REG_Y_RAW_HIGH: y_high <= cfg_data;
        default:        x_high <= x_high;
      endcase
    end
  end

  // Join the raw fields, force x to zero without y, and clamp to the windows.
  always_comb begin
    x_join = {x_top, s_tdata[15:11]};
    x_zero = (y_raw == '0) ? '0 : x_join;
    if (x_zero > x_high) begin
      x_clamp = x_high;
    end else if (x_zero < x_low) begin
      x_clamp = x_low;
    end else begin
      x_clamp = x_zero;
    end
    if (y_raw < y_low) begin
      y_clamp = y_low;
    end else if (y_raw > y_high) begin
      y_clamp = y_high;
    end else begin
      y_clamp = y_raw;
    end
  end

  // Magnitudes of numerator and window width, numerator times the span.
  always_comb begin
    x_num = (x_high >= xc) ? (x_high - xc) : (xc - x_high);
    x_den = (x_high >= x_low) ? (x_high - x_low) : (x_low - x_high);
    y_num = (yc >= y_low) ? (yc - y_low) : (y_low - yc);
    y_den = (y_high >= y_low) ? (y_high - y_low) : (y_low - y_high);
    x_dividend = DIVIDEND_W'({x_num, 8'b0}) + DIVIDEND_W'({x_num, 6'b0});
    y_dividend = DIVIDEND_W'({y_num, 7'b0}) + DIVIDEND_W'({y_num, 6'b0})
               + DIVIDEND_W'({y_num, 5'b0}) + DIVIDEND_W'({y_num, 4'b0});
  end

  tcss_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x_dividend),
    .divisor  (x_den),
    .quotient (x_quot),
    .done     (x_done)
  );

  tcss_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (y_dividend),
    .divisor  (y_den),
    .quotient (y_quot),
    .done     (y_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_accept && (word_index == WORD_THIRD)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (x_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Word counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= WORD_FIRST;
      m_tvalid   <= 1'b0;
    end else begin
      if (x_done || (s_accept && (word_index != WORD_THIRD))) begin
        m_tvalid <= 1'b1;
      end else if (m_accept) begin
        m_tvalid <= 1'b0;
      end
      if (s_accept) begin
        case (word_index)
          WORD_SECOND: word_index <= WORD_THIRD;
          WORD_THIRD:  word_index <= WORD_FIRST;
          default:     word_index <= WORD_SECOND;
        endcase
      end
    end
  end

  // Stored word fields and result payload.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      case (word_index)
        WORD_SECOND: begin
          y_raw       <= {first_low, s_tdata[15:11]};
          x_top       <= s_tdata[6:0];
          tx_word     <= TX_FLUSH;
          release_sel <= 1'b0;
          pos_valid   <= 1'b0;
          screen_x    <= '0;
          screen_y    <= '0;
        end
        WORD_THIRD: begin
          xc <= x_clamp;
          yc <= y_clamp;
        end
        default: begin
          first_low   <= s_tdata[6:0];
          tx_word     <= TX_Y_CMD;
          release_sel <= 1'b0;
          pos_valid   <= 1'b0;
          screen_x    <= '0;
          screen_y    <= '0;
        end
      endcase
    end
    if (x_done) begin
      tx_word     <= TX_START;
      release_sel <= 1'b1;
      pos_valid   <= 1'b1;
      screen_x    <= (x_high == x_low) ? X_SPAN : x_quot;
      screen_y    <= (y_high == y_low) ? Y_SPAN : y_quot[SY_W-1:0];
    end
  end

  `TCSS_ASSERT_IMP(a_out_empty_while_busy, state != ST_IDLE, !m_tvalid)
  `TCSS_ASSERT_IMP(a_screen_range, m_tvalid, (screen_x <= X_SPAN) && (screen_y <= Y_SPAN))
  `TCSS_ASSERT_NEXT(a_done_loads_output, x_done && y_done, m_tvalid && pos_valid)

endmodule
